### rtl/core/csp_pkg.sv
// Package with the shared types, character codes and helpers of the command sentence parser.
`timescale 1ns / 1ps
`default_nettype none

package csp_pkg;

  typedef logic [7:0] byte_t;

  // Five-character window at the head of a term; element 0 is the first character.
  localparam int PREFIX_DEPTH = 5;
  typedef byte_t [PREFIX_DEPTH-1:0] prefix_t;

  localparam int CMD_W             = 2;
  localparam int TERM_CAPACITY_DEF = 12;
  localparam int LEN_MAX_W         = 4;

  typedef enum logic [CMD_W-1:0] {
    CMD_CALIB = 2'd0,
    CMD_OPEN  = 2'd1,
    CMD_CLOSE = 2'd2,
    CMD_ABORT = 2'd3
  } cmd_t;

  localparam byte_t CH_DOLLAR = 8'h24;
  localparam byte_t CH_COMMA  = 8'h2C;
  localparam byte_t CH_STAR   = 8'h2A;
  localparam byte_t CH_CR     = 8'h0D;
  localparam byte_t CH_0      = 8'h30;
  localparam byte_t CH_9      = 8'h39;
  localparam byte_t CH_LA     = 8'h61;
  localparam byte_t CH_LZ     = 8'h7A;
  localparam byte_t CH_UA     = 8'h41;
  localparam byte_t CH_UZ     = 8'h5A;

  // Keywords, first character in the lowest byte.
  localparam prefix_t WORD_CMD   = 40'h00_44_4D_43_24; // "$CMD"
  localparam prefix_t WORD_CALIB = 40'h42_49_4C_41_43; // "CALIB"
  localparam prefix_t WORD_OPEN  = 40'h00_4E_45_50_4F; // "OPEN"
  localparam prefix_t WORD_CLOSE = 40'h45_53_4F_4C_43; // "CLOSE"
  localparam prefix_t WORD_ABORT = 40'h54_52_4F_42_41; // "ABORT"

  localparam logic [2:0] LEN_4 = 3'd4;
  localparam logic [2:0] LEN_5 = 3'd5;

  // True when the held term is at least n characters long and begins with word.
  function automatic logic term_starts(prefix_t p, logic [LEN_MAX_W-1:0] len,
                                       prefix_t word, logic [2:0] n);
    logic ok;
    ok = (len >= LEN_MAX_W'(n));
    for (int i = 0; i < PREFIX_DEPTH; i++) begin
      if ((i < int'(n)) && (p[i] != word[i])) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

  // Value of one checksum digit; letters of either case wrap to four bits.
  function automatic logic [3:0] hex_value(byte_t c);
    byte_t v;
    v = '0;
    if ((c >= CH_0) && (c <= CH_9)) begin
      v = c - CH_0;
    end else if ((c >= CH_LA) && (c <= CH_LZ)) begin
      v = c - CH_LA + 8'd10;
    end else if ((c >= CH_UA) && (c <= CH_UZ)) begin
      v = c - CH_UA + 8'd10;
    end
    return v[3:0];
  endfunction

endpackage

`default_nettype wire

### rtl/core/csp_ifs.sv
// Valid/ready stream interfaces for the received bytes and the accepted commands.
`timescale 1ns / 1ps
`default_nettype none

interface csp_in_if;
  logic                valid;
  logic                ready;
  logic [7:0]          rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface csp_out_if;
  logic                       valid;
  logic                       ready;
  logic [csp_pkg::CMD_W-1:0]  command;

  modport source (output valid, output command, input ready);
  modport sink   (input valid, input command, output ready);
endinterface

`default_nettype wire

### rtl/core/command_sentence_parser.sv
// Top level of the command sentence parser: byte-wise term splitting, XOR checksum, command latch.
`timescale 1ns / 1ps
`default_nettype none

// The parser takes one received byte per cycle and never stalls the input
// unless a finished command is waiting at the output and the sink holds off.
// Every byte is decoded and folded into the sentence state in the cycle of
// its transfer; a carriage return whose checksum digits match the running
// XOR, while a command is latched, registers that command onto the output,
// where it stays until it is taken. The latched command survives
// across sentences. TermCapacity sets how many characters of one term are
// counted; only the first five are kept for the keyword compare.
module command_sentence_parser #(
  parameter int TermCapacity = csp_pkg::TERM_CAPACITY_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  csp_in_if.sink    in_ch,
  csp_out_if.source out_ch
);
  import csp_pkg::*;

  localparam int LenW = $clog2(TermCapacity + 1);
  localparam logic [LenW-1:0] LenCap = LenW'(TermCapacity);

  byte_t            xor_r, xor_nxt;
  prefix_t          prefix_r, prefix_nxt;
  logic [LenW-1:0]  len_r, len_nxt;
  logic             star_r, star_nxt;
  logic             past_first_r, past_first_nxt;
  logic             is_cmd_r, is_cmd_nxt;
  logic             latch_vld_r, latch_vld_nxt;
  cmd_t             latch_cmd_r, latch_cmd_nxt;
  logic             out_valid_r, out_valid_nxt;
  cmd_t             out_cmd_r, out_cmd_nxt;

  logic             in_xfer;
  logic             emit;
  byte_t            c;
  logic [LEN_MAX_W-1:0] len_ext;
  byte_t            received;
  logic [3:0]       hi_dig, lo_dig;

  assign in_ch.ready    = !out_valid_r || out_ch.ready;
  assign in_xfer        = in_ch.valid && in_ch.ready;
  assign c              = in_ch.rx_byte;
  assign len_ext        = LEN_MAX_W'(len_r);
  assign out_ch.valid   = out_valid_r;
  assign out_ch.command = out_cmd_r;

  always_comb begin
    hi_dig   = (len_r > LenW'(0)) ? hex_value(prefix_r[0]) : 4'd0;
    lo_dig   = (len_r > LenW'(1)) ? hex_value(prefix_r[1]) : 4'd0;
    received = {hi_dig, lo_dig};

    xor_nxt        = xor_r;
    prefix_nxt     = prefix_r;
    len_nxt        = len_r;
    star_nxt       = star_r;
    past_first_nxt = past_first_r;
    is_cmd_nxt     = is_cmd_r;
    latch_vld_nxt  = latch_vld_r;
    latch_cmd_nxt  = latch_cmd_r;
    emit           = 1'b0;

    if (in_xfer) begin
      if (c == CH_DOLLAR) begin
        // A new sentence starts; only the latched command carries over.
        xor_nxt        = '0;
        prefix_nxt     = '0;
        prefix_nxt[0]  = c;
        len_nxt        = LenW'(1);
        star_nxt       = 1'b0;
        past_first_nxt = 1'b0;
        is_cmd_nxt     = 1'b0;
      end else if ((c == CH_COMMA) || (c == CH_STAR)) begin
        if (!past_first_r) begin
          is_cmd_nxt = term_starts(prefix_r, len_ext, WORD_CMD, LEN_4);
        end else if (is_cmd_r) begin
          if (term_starts(prefix_r, len_ext, WORD_CALIB, LEN_5)) begin
            latch_vld_nxt = 1'b1;
            latch_cmd_nxt = CMD_CALIB;
          end else if (term_starts(prefix_r, len_ext, WORD_OPEN, LEN_4)) begin
            latch_vld_nxt = 1'b1;
            latch_cmd_nxt = CMD_OPEN;
          end else if (term_starts(prefix_r, len_ext, WORD_CLOSE, LEN_5)) begin
            latch_vld_nxt = 1'b1;
            latch_cmd_nxt = CMD_CLOSE;
          end else if (term_starts(prefix_r, len_ext, WORD_ABORT, LEN_5)) begin
            latch_vld_nxt = 1'b1;
            latch_cmd_nxt = CMD_ABORT;
          end
        end
        past_first_nxt = 1'b1;
        len_nxt        = '0;
        if (c == CH_COMMA) begin
          // The comma counts in the checksum even after the star.
          xor_nxt = xor_r ^ c;
        end else begin
          star_nxt = 1'b1;
        end
      end else if (c == CH_CR) begin
        emit = (received == xor_r) && latch_vld_r;
      end else begin
        if (!star_r) begin
          xor_nxt = xor_r ^ c;
        end
        if (len_r < LenCap) begin
          for (int i = 0; i < PREFIX_DEPTH; i++) begin
            if (len_r == LenW'(i)) begin
              prefix_nxt[i] = c;
            end
          end
          len_nxt = len_r + LenW'(1);
        end
      end
    end

    out_valid_nxt = out_valid_r;
    out_cmd_nxt   = out_cmd_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_cmd_nxt   = latch_cmd_r;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xor_r        <= '0;
      prefix_r     <= '0;
      len_r        <= '0;
      star_r       <= 1'b0;
      past_first_r <= 1'b0;
      is_cmd_r     <= 1'b0;
      latch_vld_r  <= 1'b0;
      latch_cmd_r  <= CMD_CALIB;
      out_valid_r  <= 1'b0;
    end else begin
      xor_r        <= xor_nxt;
      prefix_r     <= prefix_nxt;
      len_r        <= len_nxt;
      star_r       <= star_nxt;
      past_first_r <= past_first_nxt;
      is_cmd_r     <= is_cmd_nxt;
      latch_vld_r  <= latch_vld_nxt;
      latch_cmd_r  <= latch_cmd_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_cmd_r <= out_cmd_nxt;
  end

  // A new result only follows a carriage return transfer with a command latched.
  a_emit_after_cr: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(in_xfer && (c == CH_CR) && latch_vld_r))
    else $error("result appeared without a carriage return");

  // The term length never passes the capacity.
  a_len_cap: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LenCap)
    else $error("term length beyond capacity");

  // A waiting result that is not taken blocks the input.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |-> !in_ch.ready)
    else $error("input open while result is stalled");

  // A dollar sign restarts the sentence with a one-character first term.
  a_dollar_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && (c == CH_DOLLAR)) |=>
      ((len_r == LenW'(1)) && !past_first_r && !star_r && (xor_r == '0)))
    else $error("sentence restart incomplete");

endmodule

`default_nettype wire
